@@ hw/rtl/sfs_pkg.sv @@
// ----------------------------------------------------------------------------
// sfs_pkg: shared types and constants of the sonar serial frame scanner
// Sensor count, action and result codes, result and queue entry structs.
// ----------------------------------------------------------------------------
package sfs_pkg;

  // Number of sensors on the shared line (1..8)
  localparam int SENSOR_COUNT = 5;
  localparam int SENSOR_IDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

  // Field widths fixed by the interface
  localparam int ACTION_W   = 2;
  localparam int DATA_W     = 8;
  localparam int ID_W       = 3;
  localparam int TIMEOUT_W  = 16;
  localparam int ELAPSED_W  = 17;
  localparam int POS_W      = 3;

  // Frame constants
  localparam logic [DATA_W-1:0]    ASCII_ZERO    = 8'h30;
  localparam logic [DATA_W-1:0]    ASCII_CR      = 8'h0D;
  localparam logic [POS_W-1:0]     POS_LAST      = 3'd4;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd200;

  // Queue between front and back
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Input actions
  localparam logic [ACTION_W-1:0] ACT_BYTE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_TICK = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_READING = 2'd0;
  localparam logic [1:0] KIND_TRIGGER = 2'd1;
  localparam logic [1:0] KIND_REPLY   = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ID_W-1:0]   sensor_id;
    logic [DATA_W-1:0] distance;
    logic              sweep_first;
    logic              sweep_last;
    logic              last;
  } sfs_result_t;

  // One queue entry: the one or two results of one input item
  typedef struct packed {
    logic        two;
    sfs_result_t r0;
    sfs_result_t r1;
  } sfs_entry_t;

  // Queue status toward both sides
  typedef struct packed {
    logic full;
    logic empty;
  } sfs_qstat_t;

endpackage

@@ hw/rtl/sfs_if.sv @@
// ----------------------------------------------------------------------------
// sfs_if: valid/ready channels of the sonar serial frame scanner
// Input item channel and result channel.
// ----------------------------------------------------------------------------
interface sfs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] rx_data;
  logic [7:0] sensor_index;

  modport source (output valid, action, rx_data, sensor_index, input ready);
  modport sink   (input valid, action, rx_data, sensor_index, output ready);
endinterface

interface sfs_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [2:0] sensor_id;
  logic [7:0] distance;
  logic       sweep_first;
  logic       sweep_last;
  logic       last;

  modport source (output valid, kind, sensor_id, distance, sweep_first, sweep_last,
                  last, input ready);
  modport sink   (input valid, kind, sensor_id, distance, sweep_first, sweep_last,
                  last, output ready);
endinterface

@@ hw/rtl/sfs_front.sv @@
// ----------------------------------------------------------------------------
// sfs_front: item decode and scanner state
// Parses frames, runs the tick timeout and sensor rotation, serves reads,
// and pushes the results of each item into the queue as one entry.
// ----------------------------------------------------------------------------
module sfs_front
  import sfs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ACTION_W-1:0]  in_action,
  input  logic [DATA_W-1:0]    in_rx_data,
  input  logic [DATA_W-1:0]    in_sensor_index,
  input  logic [TIMEOUT_W-1:0] timeout,
  input  sfs_qstat_t           qstat,
  output logic                 q_push,
  output sfs_entry_t           q_entry
);

  logic [POS_W-1:0]        byte_pos_r, byte_pos_nxt;
  logic [DATA_W-1:0]       acc_r, acc_nxt;
  logic [SENSOR_IDX_W-1:0] active_r, active_nxt;
  logic [ELAPSED_W-1:0]    elapsed_r, elapsed_nxt;
  logic [DATA_W-1:0]       readings_r [SENSOR_COUNT];

  logic                    xfer;
  logic [DATA_W-1:0]       digit;
  logic [15:0]             digit_x100;
  logic [15:0]             digit_x10;
  logic                    store;
  logic [SENSOR_IDX_W-1:0] active_inc;
  logic [ELAPSED_W-1:0]    elapsed_inc;
  logic                    in_range;
  logic [DATA_W-1:0]       read_val;
  sfs_result_t             trig, rd_res;

  assign in_ready = !qstat.full;
  assign xfer     = in_valid && in_ready;

  // Digit value and scaled terms, kept modulo 256
  assign digit      = in_rx_data - ASCII_ZERO;
  assign digit_x100 = 16'(digit) * 16'd100;
  assign digit_x10  = 16'(digit) * 16'd10;

  assign active_inc = (active_r == SENSOR_IDX_W'(SENSOR_COUNT - 1))
                      ? '0 : active_r + 1'b1;
  assign elapsed_inc = (&elapsed_r) ? elapsed_r : elapsed_r + 1'b1;

  // Read port of the reading store
  assign in_range = in_sensor_index < DATA_W'(SENSOR_COUNT);
  assign read_val = in_range ? readings_r[in_sensor_index[SENSOR_IDX_W-1:0]] : '0;

  assign store = (in_action == ACT_BYTE) && (byte_pos_r == POS_LAST) &&
                 (in_rx_data == ASCII_CR);

  // Next state and results
  always_comb begin
    byte_pos_nxt = byte_pos_r;
    acc_nxt      = acc_r;
    active_nxt   = active_r;
    elapsed_nxt  = elapsed_r;
    q_push       = 1'b0;

    trig             = '0;
    trig.kind        = KIND_TRIGGER;
    trig.sensor_id   = ID_W'(active_r);
    trig.last        = 1'b1;

    rd_res           = '0;
    rd_res.kind      = KIND_REPLY;
    rd_res.sensor_id = in_sensor_index[ID_W-1:0];
    rd_res.distance  = read_val;
    rd_res.last      = 1'b1;

    q_entry          = '0;
    q_entry.r0       = trig;

    unique case (in_action)
      ACT_BYTE: begin
        unique case (byte_pos_r)
          3'd1:    acc_nxt = digit_x100[DATA_W-1:0];
          3'd2:    acc_nxt = acc_r + digit_x10[DATA_W-1:0];
          3'd3:    acc_nxt = acc_r + digit;
          default: acc_nxt = acc_r;
        endcase
        if (byte_pos_r == POS_LAST) begin
          byte_pos_nxt = '0;
          active_nxt   = active_inc;
          q_push       = xfer;
          trig.sensor_id = ID_W'(active_inc);
          if (store) begin
            q_entry.two            = 1'b1;
            q_entry.r0             = '0;
            q_entry.r0.kind        = KIND_READING;
            q_entry.r0.sensor_id   = ID_W'(active_r);
            q_entry.r0.distance    = acc_r;
            q_entry.r0.sweep_first = (active_r == '0);
            q_entry.r0.sweep_last  = (active_r == SENSOR_IDX_W'(SENSOR_COUNT - 1));
            q_entry.r1             = trig;
          end else begin
            q_entry.r0 = trig;
          end
        end else begin
          byte_pos_nxt = byte_pos_r + 1'b1;
        end
      end
      ACT_TICK: begin
        elapsed_nxt = elapsed_inc;
        if (elapsed_inc > ELAPSED_W'(timeout)) begin
          elapsed_nxt  = '0;
          byte_pos_nxt = '0;
          q_push       = xfer;
        end
      end
      ACT_READ: begin
        q_entry.r0 = rd_res;
        q_push     = xfer;
      end
      default: ;
    endcase
  end

  // State registers, updated on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r <= '0;
      acc_r      <= '0;
      active_r   <= '0;
      elapsed_r  <= '0;
      for (int i = 0; i < SENSOR_COUNT; i++) readings_r[i] <= '0;
    end else if (xfer) begin
      byte_pos_r <= byte_pos_nxt;
      acc_r      <= acc_nxt;
      active_r   <= active_nxt;
      elapsed_r  <= elapsed_nxt;
      if (store) readings_r[active_r] <= acc_r;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_pos_r <= POS_LAST)
    else $error("byte position beyond frame end");

  a_active_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r < SENSOR_IDX_W'(SENSOR_COUNT) || SENSOR_COUNT == (1 << SENSOR_IDX_W))
    else $error("active sensor beyond sensor count");

  a_rotate: assert property (@(posedge clk) disable iff (!rst_n)
    xfer && in_action == ACT_BYTE && byte_pos_r == POS_LAST |=>
      byte_pos_r == '0 && active_r != $past(active_r) || SENSOR_COUNT == 1)
    else $error("frame end did not rotate sensor");

endmodule

@@ hw/rtl/sfs_fifo.sv @@
// ----------------------------------------------------------------------------
// sfs_fifo: result entry queue
// Short first-word-fall-through queue between the front and back parts.
// ----------------------------------------------------------------------------
module sfs_fifo
  import sfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  sfs_entry_t push_entry,
  input  logic       pop,
  output sfs_entry_t head,
  output sfs_qstat_t qstat
);

  sfs_entry_t        mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign qstat.full  = (count_r == QCNT_W'(QDEPTH));
  assign qstat.empty = (count_r == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head        = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_entry;
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("queue count overflow");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.full |-> !push)
    else $error("push into full queue");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    do_push && !do_pop |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not follow push");

endmodule

@@ hw/rtl/sfs_back.sv @@
// ----------------------------------------------------------------------------
// sfs_back: result sequencer
// Pops queue entries and presents their one or two results on the output
// register, one result per transfer.
// ----------------------------------------------------------------------------
module sfs_back
  import sfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  sfs_entry_t  head,
  input  sfs_qstat_t  qstat,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output sfs_result_t out_res
);

  logic        valid_r;
  logic        pend_r;
  sfs_result_t res_r;
  sfs_result_t second_r;
  logic        can_load;

  assign can_load  = !valid_r || out_ready;
  assign pop       = can_load && !pend_r && !qstat.empty;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  // Output register and pending second result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pend_r  <= 1'b0;
    end else if (can_load) begin
      if (pend_r) begin
        valid_r <= 1'b1;
        pend_r  <= 1'b0;
        res_r   <= second_r;
      end else if (!qstat.empty) begin
        valid_r  <= 1'b1;
        pend_r   <= head.two;
        res_r    <= head.r0;
        second_r <= head.r1;
      end else begin
        valid_r <= 1'b0;
      end
    end
  end

  a_pend_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> valid_r)
    else $error("second result pending without first shown");

  a_pend_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !res_r.last)
    else $error("first of two results flagged last");

  a_no_pop_pend: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !pop)
    else $error("queue popped while second result pending");

endmodule

@@ hw/rtl/sonar_serial_frame_scanner.sv @@
// ----------------------------------------------------------------------------
// sonar_serial_frame_scanner: serial range sensor frame scanner
// Parses five-byte ASCII range frames from sensors sharing one line, rotates
// triggers round-robin, handles tick timeouts and serves reading lookups.
// ----------------------------------------------------------------------------
// The block accepts one input item per clock cycle while its four-entry
// result queue has room; items are decoded and the scanner state updated in
// the cycle they are accepted. The output register delivers one result per
// cycle while the result side is ready, so a carriage-return frame end
// (reading plus trigger) gives two result transfers and the sustained rate
// is set by the result port: one item per cycle when items give one result
// or none. With an idle queue, an accepted item's entry is written to the
// queue, then loaded into the output register. Readings clear at reset.
module sonar_serial_frame_scanner
  import sfs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  sfs_in_if.sink               in_ch,
  sfs_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [TIMEOUT_W-1:0] cfg_wdata
);

  logic [TIMEOUT_W-1:0] timeout_r;
  logic                 q_push, q_pop;
  sfs_entry_t           q_entry, q_head;
  sfs_qstat_t           qstat;
  sfs_result_t          out_res;

  // Timeout register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_r <= cfg_wdata;
    end
  end

  sfs_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_action       (in_ch.action),
    .in_rx_data      (in_ch.rx_data),
    .in_sensor_index (in_ch.sensor_index),
    .timeout         (timeout_r),
    .qstat           (qstat),
    .q_push          (q_push),
    .q_entry         (q_entry)
  );

  sfs_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .qstat      (qstat)
  );

  sfs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .qstat     (qstat),
    .pop       (q_pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  // Result payload onto the output channel
  assign out_ch.kind        = out_res.kind;
  assign out_ch.sensor_id   = out_res.sensor_id;
  assign out_ch.distance    = out_res.distance;
  assign out_ch.sweep_first = out_res.sweep_first;
  assign out_ch.sweep_last  = out_res.sweep_last;
  assign out_ch.last        = out_res.last;

  a_ready_queue: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready == !qstat.full)
    else $error("input ready disagrees with queue state");

  // entry lands in the queue, then the back part loads it in the next cycle
  a_out_after_push: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && qstat.empty && !out_ch.valid |=> ##1 out_ch.valid)
    else $error("queued result not presented");

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> timeout_r == $past(cfg_wdata))
    else $error("timeout register not written");

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sonar_serial_frame_scanner
// Feeds serial bytes, timer ticks and reading lookups through valid/ready
// channels, with random gaps on both sides. It predicts every result with
// its own model of the frame scanner, but for typed directed replies, and
// walks the tick timeout through several settings, 0 and 65535 among them.
// ----------------------------------------------------------------------------
module testbench;
  import sfs_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASE_ITEMS   = 230;
  localparam int MAX_WAIT      = 17;

  // action 3 has no meaning; the block drops it
  localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

  // byte positions inside a frame that carry digits
  localparam logic [POS_W-1:0] POS_HUNDREDS = 3'd1;
  localparam logic [POS_W-1:0] POS_TENS     = 3'd2;
  localparam logic [POS_W-1:0] POS_UNITS    = 3'd3;

  // timeout settings for the random phases after the first one
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_PLAN [6] =
    '{16'd0, 16'd1, 16'hFFFF, 16'd3, 16'd9, TIMEOUT_RESET};

  // directed rows; chk marks a row whose reply is typed in
  typedef struct packed {
    logic [ACTION_W-1:0] act;
    logic [DATA_W-1:0]   data;
    logic [7:0]          idx;
    logic                chk;
    logic [1:0]          kind;
    logic [ID_W-1:0]     id;
    logic [DATA_W-1:0]   distance;
  } dir_row_t;

  localparam int DIR_ROWS = 25;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{ACT_READ, 8'h00, 8'd0,   1'b1, KIND_REPLY, 3'd0, 8'd0},  // empty store
    '{ACT_READ, 8'hFF, 8'd4,   1'b1, KIND_REPLY, 3'd4, 8'd0},
    '{ACT_READ, 8'h00, 8'd5,   1'b1, KIND_REPLY, 3'd5, 8'd0},  // first index past count
    '{ACT_READ, 8'hFF, 8'd255, 1'b1, KIND_REPLY, 3'd7, 8'd0},  // top index
    '{ACT_NONE, 8'hFF, 8'd255, 1'b0, KIND_REPLY, 3'd0, 8'd0},
    '{ACT_TICK, 8'h00, 8'd0,   1'b0, KIND_REPLY, 3'd0, 8'd0},
    // good frame "123" for sensor 0
    '{ACT_BYTE, 8'h53, 8'd0,   1'b0, KIND_REPLY, 3'd0, 8'd0},
    '{ACT_BYTE, 8'h31, 8'd0,   1'b0, KIND_REPLY, 3'd0, 8'd0},
    '{ACT_BYTE, 8'h32, 8'd0,   1'b0, KIND_REPLY, 3'd0, 8'd0},
    '{ACT_BYTE, 8'h33, 8'd0,   1'b0, KIND_REPLY, 3'd0, 8'd0},
    '{ACT_BYTE, ASCII_CR, 8'd0, 1'b0, KIND_REPLY, 3'd0, 8'd0},
    '{ACT_READ, 8'h00, 8'd0,   1'b0, KIND_REPLY, 3'd0, 8'd0},
    // non-digit bytes, one digit and a bad terminator
    '{ACT_BYTE, 8'h00, 8'd255, 1'b0, KIND_REPLY, 3'd0, 8'd0},
    '{ACT_BYTE, 8'hFF, 8'd0,   1'b0, KIND_REPLY, 3'd0, 8'd0},
    '{ACT_BYTE, 8'h00, 8'd0,   1'b0, KIND_REPLY, 3'd0, 8'd0},
    '{ACT_BYTE, 8'h39, 8'd0,   1'b0, KIND_REPLY, 3'd0, 8'd0},
    '{ACT_BYTE, 8'hFF, 8'd0,   1'b0, KIND_REPLY, 3'd0, 8'd0},
    // "999" wraps modulo 256
    '{ACT_BYTE, 8'h52, 8'd0,   1'b0, KIND_REPLY, 3'd0, 8'd0},
    '{ACT_BYTE, 8'h39, 8'd0,   1'b0, KIND_REPLY, 3'd0, 8'd0},
    '{ACT_BYTE, 8'h39, 8'd0,   1'b0, KIND_REPLY, 3'd0, 8'd0},
    '{ACT_BYTE, 8'h39, 8'd0,   1'b0, KIND_REPLY, 3'd0, 8'd0},
    '{ACT_BYTE, ASCII_CR, 8'd0, 1'b0, KIND_REPLY, 3'd0, 8'd0},
    '{ACT_READ, 8'h00, 8'd2,   1'b0, KIND_REPLY, 3'd0, 8'd0},
    '{ACT_TICK, 8'hFF, 8'd255, 1'b0, KIND_REPLY, 3'd0, 8'd0},
    '{ACT_NONE, 8'h00, 8'd0,   1'b0, KIND_REPLY, 3'd0, 8'd0}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [TIMEOUT_W-1:0] cfg_wdata;

  sfs_in_if  in_bus ();
  sfs_out_if out_bus ();

  sonar_serial_frame_scanner u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // scanner state as the bench sees it
  logic [POS_W-1:0]     frame_pos;
  logic [DATA_W-1:0]    digit_sum;
  logic [ID_W-1:0]      serving;
  logic [ELAPSED_W-1:0] ticks_seen;
  logic [DATA_W-1:0]    stored_range [SENSOR_COUNT];
  logic [TIMEOUT_W-1:0] timeout_limit;

  // results of the item just accepted, and all results still owed
  sfs_result_t step_res [2];
  int          step_n;
  sfs_result_t expected_results [$];

  int unsigned cycle_count;
  int unsigned fail_count;
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_readings;
  int unsigned n_triggers;
  int unsigned n_replies;
  int unsigned n_timeouts;
  bit          send_burst;
  bit          sink_burst;
  int unsigned sink_wait;

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int unsigned draw_wait(bit burst);
    return burst ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  function void add_result(logic [1:0] kind, logic [ID_W-1:0] id, logic [DATA_W-1:0] distance,
                           logic first, logic final_sensor);
    step_res[step_n].kind        = kind;
    step_res[step_n].sensor_id   = id;
    step_res[step_n].distance    = distance;
    step_res[step_n].sweep_first = first;
    step_res[step_n].sweep_last  = final_sensor;
    step_res[step_n].last        = 1'b0;
    step_n++;
  endfunction

  // frame scanner prediction for one accepted item
  function void scan_item(logic [ACTION_W-1:0] act, logic [DATA_W-1:0] data, logic [7:0] idx);
    logic [DATA_W-1:0] digit;
    step_n = 0;
    digit  = data - ASCII_ZERO;
    case (act)
      ACT_BYTE: begin
        case (frame_pos)
          POS_HUNDREDS: digit_sum = digit * 8'd100;
          POS_TENS:     digit_sum = digit_sum + digit * 8'd10;
          POS_UNITS:    digit_sum = digit_sum + digit;
          POS_LAST: begin
            if (data == ASCII_CR) begin
              stored_range[serving] = digit_sum;
              add_result(KIND_READING, serving, digit_sum, serving == 0,
                         serving == SENSOR_COUNT - 1);
            end
          end
          default: ;
        endcase
        // every fifth byte hands over to the next sensor
        if (frame_pos == POS_LAST) begin
          frame_pos = '0;
          serving   = (serving == SENSOR_COUNT - 1) ? '0 : serving + 1'b1;
          add_result(KIND_TRIGGER, serving, '0, 1'b0, 1'b0);
        end else begin
          frame_pos = frame_pos + 1'b1;
        end
      end
      ACT_TICK: begin
        if (ticks_seen != '1) ticks_seen = ticks_seen + 1'b1;
        if (ticks_seen > {1'b0, timeout_limit}) begin
          ticks_seen = '0;
          frame_pos  = '0;
          n_timeouts++;
          add_result(KIND_TRIGGER, serving, '0, 1'b0, 1'b0);
        end
      end
      ACT_READ: begin
        add_result(KIND_REPLY, idx[ID_W-1:0],
                   (idx < SENSOR_COUNT) ? stored_range[idx[ID_W-1:0]] : '0, 1'b0, 1'b0);
      end
      default: ;
    endcase
    if (step_n > 0) step_res[step_n-1].last = 1'b1;
  endfunction

  // one input transfer, after a random gap; called on a rising edge
  task automatic send_item(input logic [ACTION_W-1:0] act, input logic [DATA_W-1:0] data,
                           input logic [7:0] idx, input logic use_typed = 1'b0,
                           input sfs_result_t typed = '0);
    int unsigned gap;
    gap = draw_wait(send_burst);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.action       <= act;
    in_bus.rx_data      <= data;
    in_bus.sensor_index <= idx;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    scan_item(act, data, idx);
    if (use_typed) begin
      expected_results.push_back(typed);
    end else begin
      for (int k = 0; k < step_n; k++) expected_results.push_back(step_res[k]);
    end
    if (act != ACT_NONE) n_sent++;
  endtask

  // hold off the sender until everything owed has arrived
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we        <= 1'b0;
    timeout_limit  = value;
  endtask

  // lead byte, three digits, terminator; mostly well formed
  task automatic send_frame();
    logic [DATA_W-1:0] b;
    send_item(ACT_BYTE, $urandom_range(0, 255), $urandom_range(0, 255));
    for (int k = 0; k < 3; k++) begin
      if ($urandom_range(0, 9) == 0) b = $urandom_range(0, 255);
      else b = ASCII_ZERO + $urandom_range(0, 9);
      send_item(ACT_BYTE, b, $urandom_range(0, 255));
      if ($urandom_range(0, 19) == 0)
        send_item(ACT_READ, $urandom_range(0, 255), $urandom_range(0, SENSOR_COUNT - 1));
    end
    b = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : ASCII_CR;
    send_item(ACT_BYTE, b, $urandom_range(0, 255));
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned goal;
    int unsigned pick;
    int unsigned run_len;
    goal = n_sent + count;
    while (n_sent < goal) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 49) == 0) send_burst = !send_burst;
      if (pick < 55) begin
        send_frame();
      end else if (pick < 75) begin
        // tick runs; now and then a long one to reach large timeouts
        run_len = ($urandom_range(0, 39) == 0) ? $urandom_range(1, 260) : $urandom_range(1, 6);
        repeat (run_len) send_item(ACT_TICK, $urandom_range(0, 255), $urandom_range(0, 255));
      end else if (pick < 88) begin
        send_item(ACT_READ, $urandom_range(0, 255),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                              : $urandom_range(0, SENSOR_COUNT - 1));
      end else if (pick < 98) begin
        send_item(($urandom_range(0, 1) == 0) ? ACT_BYTE : ACT_NONE,
                  $urandom_range(0, 255), $urandom_range(0, 255));
      end else begin
        drain_results();
      end
    end
  endtask

  function void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  function void check_result();
    sfs_result_t want;
    if (expected_results.size() == 0) begin
      $error("result with nothing expected: kind %0d sensor_id %0d distance %0d",
             out_bus.kind, out_bus.sensor_id, out_bus.distance);
      fail_count++;
      return;
    end
    want = expected_results.pop_front();
    n_checked++;
    case (want.kind)
      KIND_READING: n_readings++;
      KIND_TRIGGER: n_triggers++;
      default:      n_replies++;
    endcase
    check_field("kind", want.kind, out_bus.kind);
    check_field("sensor_id", want.sensor_id, out_bus.sensor_id);
    check_field("distance", want.distance, out_bus.distance);
    check_field("sweep_first", want.sweep_first, out_bus.sweep_first);
    check_field("sweep_last", want.sweep_last, out_bus.sweep_last);
    check_field("last", want.last, out_bus.last);
  endfunction

  // result side: check each transfer, then stall for a random while
  always @(posedge clk) begin
    if (out_bus.valid && out_bus.ready) begin
      check_result();
      if ($urandom_range(0, 49) == 0) sink_burst = !sink_burst;
      sink_wait = draw_wait(sink_burst);
      if (sink_wait > 0) out_bus.ready <= 1'b0;
    end else if (!out_bus.ready) begin
      if (sink_wait == 0) out_bus.ready <= 1'b1;
      else sink_wait--;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // main sequence
  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    in_bus.valid        = 1'b0;
    in_bus.action       = ACT_BYTE;
    in_bus.rx_data      = '0;
    in_bus.sensor_index = '0;
    out_bus.ready       = 1'b0;
    sink_wait           = 0;
    send_burst          = 1'b0;
    sink_burst          = 1'b0;
    cycle_count         = 0;
    fail_count          = 0;
    n_sent              = 0;
    n_checked           = 0;
    n_readings          = 0;
    n_triggers          = 0;
    n_replies           = 0;
    n_timeouts          = 0;
    frame_pos           = '0;
    digit_sum           = '0;
    serving             = '0;
    ticks_seen          = '0;
    timeout_limit       = TIMEOUT_RESET;
    foreach (stored_range[i]) stored_range[i] = '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows at the reset timeout
    for (int r = 0; r < DIR_ROWS; r++) begin
      send_item(DIRECTED[r].act, DIRECTED[r].data, DIRECTED[r].idx, DIRECTED[r].chk,
                '{DIRECTED[r].kind, DIRECTED[r].id, DIRECTED[r].distance, 1'b0, 1'b0, 1'b1});
    end

    // random phases, each under its own timeout
    run_random(PHASE_ITEMS);
    for (int ph = 0; ph < 7; ph++) begin
      write_timeout((ph < 6) ? TIMEOUT_PLAN[ph] : 16'($urandom_range(0, 64)));
      run_random(PHASE_ITEMS);
    end

    drain_results();
    $display("testbench: %0d items, %0d results checked: %0d readings, %0d triggers, %0d replies",
             n_sent, n_checked, n_readings, n_triggers, n_replies);
    $display("testbench: %0d tick timeouts over eight timeout settings from 0 to 65535",
             n_timeouts);
    if (fail_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/sfs_pkg.sv
hw/rtl/sfs_if.sv
hw/rtl/sfs_front.sv
hw/rtl/sfs_fifo.sv
hw/rtl/sfs_back.sv
hw/rtl/sonar_serial_frame_scanner.sv
sim/testbench.sv
